// File: hw/rtl/ddwp_pkg.sv
// Differential drive wheel PWM: shared widths, register codes, reset values
// and bundle types. Used by every module of the block; depends on nothing.

package ddwp_pkg;

  // Register file
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RPM     = 3'd0,
    REG_WHEEL_CIRC  = 3'd1,
    REG_WHEEL_TRACK = 3'd2,
    REG_GEAR_RATIO  = 3'd3,
    REG_LEFT_SCALE  = 3'd4,
    REG_RIGHT_SCALE = 3'd5,
    REG_TURN_GAIN   = 3'd6
  } cfg_reg_e;

  localparam int RPM_W  = 14;
  localparam int DUTY_W = 8;
  localparam int CIRC_W = 16;
  localparam int FS_W   = 16;

  localparam logic [RPM_W-1:0] MAX_RPM_RST     = 14'd330;
  localparam logic [CFG_W-1:0] WHEEL_CIRC_RST  = 16'd13998;
  localparam logic [CFG_W-1:0] WHEEL_TRACK_RST = 16'd3277;
  localparam logic [CFG_W-1:0] GEAR_RATIO_RST  = 16'd256;
  localparam logic [CFG_W-1:0] LEFT_SCALE_RST  = 16'd16384;
  localparam logic [CFG_W-1:0] RIGHT_SCALE_RST = 16'd16384;
  localparam logic [CFG_W-1:0] TURN_GAIN_RST   = 16'd4096;

  // Datapath widths
  localparam int BASE_SHIFT = 27;                 // forward speed to Q.39 turn scale
  localparam int BASE_W     = FS_W + BASE_SHIFT;
  localparam int GT_W       = 2 * CFG_W;          // turn_gain * wheel_track
  localparam int GS_W       = 2 * CFG_W;          // gear_ratio * side_scale
  localparam int TURN_W     = 49;
  localparam int SUM_W      = 49;
  localparam int MAG_W      = SUM_W - 1;
  localparam int X60_W      = MAG_W + 6;
  localparam int NUM_SHIFT  = 7;
  localparam int NUM_W      = X60_W - NUM_SHIFT;  // dividend and quotient width
  localparam int QLO_W      = 24;
  localparam int QHI_W      = NUM_W - QLO_W;
  localparam int PROD_W     = NUM_W + GS_W;
  localparam int FRAC_W     = 38;
  localparam int P_W        = RPM_W + FRAC_W;
  localparam int T_W        = RPM_W + DUTY_W;

  // abs, x60, quotient steps, two multiply stages, clamp, x255, duty steps
  localparam int WHEEL_LAT = 2 + NUM_W + 4 + DUTY_W;
  // input, turn multiply, left/right sum, then the wheel pipes
  localparam int PIPE_LAT  = 3 + WHEEL_LAT;

  typedef struct packed {
    logic [CIRC_W-1:0] circ;
    logic [GS_W-1:0]   gs;
    logic [RPM_W-1:0]  max_rpm;
  } wheel_cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic              left_forward;
    logic [RPM_W-1:0]  left_rpm;
    logic [DUTY_W-1:0] right_duty;
    logic              right_forward;
    logic [RPM_W-1:0]  right_rpm;
  } result_t;

endpackage

// File: hw/rtl/ddwp_wheel.sv
// One wheel datapath: signed rpm sum to clamped magnitude, rpm and duty.
// Depends on ddwp_pkg; fully pipelined, advances on en_i.

module ddwp_wheel import ddwp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  wheel_cfg_t              cfg_i,
  output logic [DUTY_W-1:0]       duty_o,
  output logic                    neg_o,
  output logic [RPM_W-1:0]        rpm_o
);

  // magnitude and sign
  logic [MAG_W-1:0] abs_d, abs_q;
  logic             neg1_q;

  assign abs_d = sum_i[SUM_W-1] ? MAG_W'(-sum_i) : MAG_W'(sum_i);

  // times 60, then drop the 2^7 part of the divisor
  logic [X60_W-1:0] x60;
  logic [NUM_W-1:0] num_q;
  logic             neg2_q;

  assign x60 = {abs_q, 6'b0} - {4'b0, abs_q, 2'b0};

  // restoring divide by circumference, one quotient bit per stage
  logic [CIRC_W-1:0] drem_d [NUM_W];
  logic [CIRC_W-1:0] drem_q [NUM_W];
  logic [NUM_W-1:0]  dw_d   [NUM_W];
  logic [NUM_W-1:0]  dw_q   [NUM_W];
  logic              dneg_q [NUM_W];

  always_comb begin
    logic [CIRC_W-1:0] rin;
    logic [NUM_W-1:0]  win;
    logic [CIRC_W:0]   trial;
    logic [CIRC_W+1:0] diff;
    for (int i = 0; i < NUM_W; i++) begin
      rin   = (i == 0) ? '0 : drem_q[(i == 0) ? 0 : i-1];
      win   = (i == 0) ? num_q : dw_q[(i == 0) ? 0 : i-1];
      trial = {rin, win[NUM_W-1]};
      diff  = {1'b0, trial} - {2'b0, cfg_i.circ};
      drem_d[i] = diff[CIRC_W+1] ? trial[CIRC_W-1:0] : diff[CIRC_W-1:0];
      dw_d[i]   = {win[NUM_W-2:0], ~diff[CIRC_W+1]};
    end
  end

  // quotient times gear*scale, split in two partial products
  logic [NUM_W-1:0]        quot;
  logic [QHI_W+GS_W-1:0]   ph_q;
  logic [QLO_W+GS_W-1:0]   pl_q;
  logic                    neg3_q;
  logic [PROD_W-1:0]       prod_q;
  logic                    neg4_q;

  assign quot = dw_q[NUM_W-1];

  // clamp to max rpm
  logic [P_W-1:0]    lim;
  logic [P_W-1:0]    p_q;
  logic              neg5_q;

  assign lim = {cfg_i.max_rpm, {FRAC_W{1'b0}}};

  // duty numerator: floor(p*255 / 2^38)
  logic [P_W+DUTY_W-1:0] p255;
  logic [T_W-1:0]        t_q;
  logic [RPM_W-1:0]      rpm6_q;
  logic                  neg6_q;

  assign p255 = {p_q, {DUTY_W{1'b0}}} - {{DUTY_W{1'b0}}, p_q};

  // restoring divide by max rpm; quotient fits the duty width
  logic [RPM_W-1:0]  trem_d [DUTY_W];
  logic [RPM_W-1:0]  trem_q [DUTY_W];
  logic [DUTY_W-1:0] tw_d   [DUTY_W];
  logic [DUTY_W-1:0] tw_q   [DUTY_W];
  logic [RPM_W-1:0]  trpm_q [DUTY_W];
  logic              tneg_q [DUTY_W];

  always_comb begin
    logic [RPM_W-1:0]  rin;
    logic [DUTY_W-1:0] win;
    logic [RPM_W:0]    trial;
    logic [RPM_W+1:0]  diff;
    for (int i = 0; i < DUTY_W; i++) begin
      rin   = (i == 0) ? t_q[T_W-1:DUTY_W] : trem_q[(i == 0) ? 0 : i-1];
      win   = (i == 0) ? t_q[DUTY_W-1:0] : tw_q[(i == 0) ? 0 : i-1];
      trial = {rin, win[DUTY_W-1]};
      diff  = {1'b0, trial} - {2'b0, cfg_i.max_rpm};
      trem_d[i] = diff[RPM_W+1] ? trial[RPM_W-1:0] : diff[RPM_W-1:0];
      tw_d[i]   = {win[DUTY_W-2:0], ~diff[RPM_W+1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q  <= abs_d;
      neg1_q <= sum_i[SUM_W-1];

      num_q  <= x60[X60_W-1:NUM_SHIFT];
      neg2_q <= neg1_q;

      for (int i = 0; i < NUM_W; i++) begin
        drem_q[i] <= drem_d[i];
        dw_q[i]   <= dw_d[i];
        dneg_q[i] <= (i == 0) ? neg2_q : dneg_q[(i == 0) ? 0 : i-1];
      end

      ph_q   <= {{GS_W{1'b0}}, quot[NUM_W-1:QLO_W]} * {{QHI_W{1'b0}}, cfg_i.gs};
      pl_q   <= {{GS_W{1'b0}}, quot[QLO_W-1:0]} * {{QLO_W{1'b0}}, cfg_i.gs};
      neg3_q <= dneg_q[NUM_W-1];

      prod_q <= {ph_q, {QLO_W{1'b0}}} + PROD_W'(pl_q);
      neg4_q <= neg3_q;

      p_q    <= (prod_q > PROD_W'(lim)) ? lim : prod_q[P_W-1:0];
      neg5_q <= neg4_q;

      // a zero magnitude counts as non-negative
      t_q    <= p255[P_W+DUTY_W-1:FRAC_W];
      rpm6_q <= p_q[P_W-1:FRAC_W];
      neg6_q <= neg5_q && (p_q != '0);

      for (int i = 0; i < DUTY_W; i++) begin
        trem_q[i] <= trem_d[i];
        tw_q[i]   <= tw_d[i];
        trpm_q[i] <= (i == 0) ? rpm6_q : trpm_q[(i == 0) ? 0 : i-1];
        tneg_q[i] <= (i == 0) ? neg6_q : tneg_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign duty_o = tw_q[DUTY_W-1];
  assign rpm_o  = trpm_q[DUTY_W-1];
  assign neg_o  = tneg_q[DUTY_W-1];

endmodule

// File: hw/rtl/diff_drive_wheel_pwm.sv
// Differential drive wheel PWM top level: register file, turn/sum front end,
// two wheel pipes and the output register with skid. Depends on ddwp_pkg, ddwp_wheel.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------------
//   command  | in        | in_valid_i / in_ready_o    | forward_speed_i, turn_rate_i
//   result   | out       | out_valid_o / out_ready_i  | left_/right_ duty, forward, rpm
//   config   | in        | cfg_we_i (no wait)         | cfg_index_i, cfg_wdata_i
//
// One command per clock while in_ready_o is high; the pipeline depth is set
// mostly by the 47 quotient steps of the circumference divide.
// Reset loads the register defaults and empties the pipeline.
// A stalled result sits in the output register while one more lands in the skid
// register; in_ready_o drops only while the skid register is full.

module diff_drive_wheel_pwm import ddwp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [FS_W-1:0] forward_speed_i,
  input  logic signed [FS_W-1:0] turn_rate_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DUTY_W-1:0]    left_duty_o,
  output logic                 left_forward_o,
  output logic [RPM_W-1:0]     left_rpm_o,
  output logic [DUTY_W-1:0]    right_duty_o,
  output logic                 right_forward_o,
  output logic [RPM_W-1:0]     right_rpm_o
);

  // register file
  logic [RPM_W-1:0] max_rpm_q;
  logic [CFG_W-1:0] wheel_circ_q, wheel_track_q, gear_ratio_q;
  logic [CFG_W-1:0] left_scale_q, right_scale_q, turn_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rpm_q     <= MAX_RPM_RST;
      wheel_circ_q  <= WHEEL_CIRC_RST;
      wheel_track_q <= WHEEL_TRACK_RST;
      gear_ratio_q  <= GEAR_RATIO_RST;
      left_scale_q  <= LEFT_SCALE_RST;
      right_scale_q <= RIGHT_SCALE_RST;
      turn_gain_q   <= TURN_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MAX_RPM:     max_rpm_q     <= cfg_wdata_i[RPM_W-1:0];
        REG_WHEEL_CIRC:  wheel_circ_q  <= cfg_wdata_i;
        REG_WHEEL_TRACK: wheel_track_q <= cfg_wdata_i;
        REG_GEAR_RATIO:  gear_ratio_q  <= cfg_wdata_i;
        REG_LEFT_SCALE:  left_scale_q  <= cfg_wdata_i;
        REG_RIGHT_SCALE: right_scale_q <= cfg_wdata_i;
        REG_TURN_GAIN:   turn_gain_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // products of register pairs and the guarded circumference, refreshed every cycle
  logic [GT_W-1:0]   gt_q;
  logic [GS_W-1:0]   gs_l_q, gs_r_q;
  logic [CIRC_W-1:0] circ_q;

  always_ff @(posedge clk_i) begin
    gt_q   <= turn_gain_q * wheel_track_q;
    gs_l_q <= gear_ratio_q * left_scale_q;
    gs_r_q <= gear_ratio_q * right_scale_q;
    // a zero circumference counts as one LSB
    circ_q <= (wheel_circ_q == '0) ? CIRC_W'(1) : wheel_circ_q;
  end

  // pipeline control
  logic                skid_valid_q;
  logic                out_valid_q;
  logic                en;
  logic [PIPE_LAT-1:0] v_q;

  assign en         = ~skid_valid_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // front end: input, turn product, left and right sums
  logic signed [FS_W-1:0]   fs_q, tr_q;
  logic signed [BASE_W-1:0] base_q;
  logic signed [TURN_W-1:0] turn_q;
  logic signed [SUM_W-1:0]  sum_l_q, sum_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fs_q    <= forward_speed_i;
      tr_q    <= turn_rate_i;
      base_q  <= {fs_q, {BASE_SHIFT{1'b0}}};
      // 33 x 16 signed
      turn_q  <= $signed({1'b0, gt_q}) * tr_q;
      sum_l_q <= SUM_W'(base_q) - turn_q;
      sum_r_q <= SUM_W'(base_q) + turn_q;
    end
  end

  // wheel pipes
  wheel_cfg_t        cfg_l, cfg_r;
  logic [DUTY_W-1:0] duty_l, duty_r;
  logic [RPM_W-1:0]  rpm_l, rpm_r;
  logic              neg_l, neg_r;

  assign cfg_l = '{circ: circ_q, gs: gs_l_q, max_rpm: max_rpm_q};
  assign cfg_r = '{circ: circ_q, gs: gs_r_q, max_rpm: max_rpm_q};

  ddwp_wheel u_wheel_l (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_l_q),
    .cfg_i  (cfg_l),
    .duty_o (duty_l),
    .neg_o  (neg_l),
    .rpm_o  (rpm_l)
  );

  ddwp_wheel u_wheel_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_r_q),
    .cfg_i  (cfg_r),
    .duty_o (duty_r),
    .neg_o  (neg_r),
    .rpm_o  (rpm_r)
  );

  // the right motor is mounted reversed
  result_t pipe_res;
  logic    pipe_v;
  logic    zero_max;

  assign pipe_v   = v_q[PIPE_LAT-1];
  assign zero_max = (max_rpm_q == '0);

  always_comb begin
    pipe_res.left_duty     = zero_max ? '0 : duty_l;
    pipe_res.left_forward  = neg_l;
    pipe_res.left_rpm      = rpm_l;
    pipe_res.right_duty    = zero_max ? '0 : duty_r;
    pipe_res.right_forward = ~neg_r;
    pipe_res.right_rpm     = rpm_r;
  end

  // output register and skid
  result_t out_q, skid_q;
  logic    out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_q <= pipe_v;
    end else if (pipe_v) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= pipe_res;
    end else begin
      skid_q <= pipe_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_duty_o     = out_q.left_duty;
  assign left_forward_o  = out_q.left_forward;
  assign left_rpm_o      = out_q.left_rpm;
  assign right_duty_o    = out_q.right_duty;
  assign right_forward_o = out_q.right_forward;
  assign right_rpm_o     = out_q.right_rpm;

endmodule

// File: hw/rtl/ddwp_checker.sv
// Port-level checks for the differential drive wheel PWM block, bound to the top level.
// Depends on ddwp_pkg.

module ddwp_checker import ddwp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DUTY_W-1:0] left_duty_o,
  input logic              left_forward_o,
  input logic [RPM_W-1:0]  left_rpm_o,
  input logic [DUTY_W-1:0] right_duty_o,
  input logic              right_forward_o,
  input logic [RPM_W-1:0]  right_rpm_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_duty_o)
      && $stable(left_forward_o) && $stable(left_rpm_o) && $stable(right_duty_o)
      && $stable(right_forward_o) && $stable(right_rpm_o))
    else $error("result changed while stalled");

  // back pressure only with a result waiting at the output
  a_ready_low_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("request blocked with no result pending");

  // skid drains in the cycle the output is taken
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o)
    else $error("skid did not drain");

  // skid holds while the output is not taken
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o && out_valid_o)
    else $error("skid content lost");

endmodule

bind diff_drive_wheel_pwm ddwp_checker u_checker (.*);

// File: sim/tb_diff_drive_wheel_pwm.sv
// Testbench for diff_drive_wheel_pwm: random and corner velocity commands under
// several register settings, checked against a wheel speed predictor held in a
// scoreboard class. Depends on ddwp_pkg and the diff_drive_wheel_pwm RTL.

class wheel_pwm_board;
  logic [13:0] max_rpm;
  logic [15:0] circ;
  logic [15:0] track;
  logic [15:0] gear;
  logic [15:0] lscale;
  logic [15:0] rscale;
  logic [15:0] tgain;
  ddwp_pkg::result_t expected_pwm[$];
  int unsigned mismatches;
  int unsigned commands;
  int unsigned checked;

  function new();
    max_rpm     = ddwp_pkg::MAX_RPM_RST;
    circ        = ddwp_pkg::WHEEL_CIRC_RST;
    track       = ddwp_pkg::WHEEL_TRACK_RST;
    gear        = ddwp_pkg::GEAR_RATIO_RST;
    lscale      = ddwp_pkg::LEFT_SCALE_RST;
    rscale      = ddwp_pkg::RIGHT_SCALE_RST;
    tgain       = ddwp_pkg::TURN_GAIN_RST;
    mismatches  = 0;
    commands    = 0;
    checked     = 0;
  endfunction

  function void write_reg(logic [ddwp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      ddwp_pkg::REG_MAX_RPM:     max_rpm = data[13:0];
      ddwp_pkg::REG_WHEEL_CIRC:  circ    = data;
      ddwp_pkg::REG_WHEEL_TRACK: track   = data;
      ddwp_pkg::REG_GEAR_RATIO:  gear    = data;
      ddwp_pkg::REG_LEFT_SCALE:  lscale  = data;
      ddwp_pkg::REG_RIGHT_SCALE: rscale  = data;
      ddwp_pkg::REG_TURN_GAIN:   tgain   = data;
      default: ;  // no register behind this index
    endcase
  endfunction

  // One wheel: magnitude in Q16 rpm, gear and side scale into Q38, clamp, duty.
  function void wheel_speed(longint a, logic [15:0] scale, output logic [7:0] duty,
                            output logic neg, output logic [13:0] rpm);
    logic [63:0] circ_eff, lim, mag, quo, p1, p;
    circ_eff = (circ == 16'd0) ? 64'd1 : 64'(circ);
    lim = 64'(max_rpm) << ddwp_pkg::FRAC_W;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    quo = mag / (circ_eff << 7);
    p1 = quo * 64'(gear);
    if (scale != 16'd0 && p1 > lim / 64'(scale)) p = lim;
    else p = p1 * 64'(scale);
    if (p > lim) p = lim;
    neg = (a < 0) && (p != 64'd0);
    rpm = 14'(p >> ddwp_pkg::FRAC_W);
    duty = (lim == 64'd0) ? 8'd0 : 8'((p * 64'd255) / lim);
  endfunction

  function ddwp_pkg::result_t predict_wheels(logic signed [15:0] fs, logic signed [15:0] tr);
    longint base, turn, al, ar;
    logic neg;
    ddwp_pkg::result_t r;
    base = longint'(fs) <<< 27;
    turn = longint'(tgain) * longint'(track) * longint'(tr);
    al = 60 * (base - turn);
    ar = 60 * (base + turn);
    wheel_speed(al, lscale, r.left_duty, neg, r.left_rpm);
    r.left_forward = neg;
    // right motor is mounted mirrored
    wheel_speed(ar, rscale, r.right_duty, neg, r.right_rpm);
    r.right_forward = !neg;
    return r;
  endfunction

  function void note_command(logic signed [15:0] fs, logic signed [15:0] tr);
    expected_pwm.push_back(predict_wheels(fs, tr));
    commands++;
  endfunction

  function void field_check(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(ddwp_pkg::result_t got);
    ddwp_pkg::result_t want;
    if (expected_pwm.size() == 0) begin
      $display("%0t: result with no command pending, expected none, got %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_pwm.pop_front();
    checked++;
    field_check("left_duty", want.left_duty, got.left_duty);
    field_check("left_forward", want.left_forward, got.left_forward);
    field_check("left_rpm", want.left_rpm, got.left_rpm);
    field_check("right_duty", want.right_duty, got.right_duty);
    field_check("right_forward", want.right_forward, got.right_forward);
    field_check("right_rpm", want.right_rpm, got.right_rpm);
  endfunction

  function int pending();
    return expected_pwm.size();
  endfunction
endclass

module tb_diff_drive_wheel_pwm;
  import ddwp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 200000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [FS_W-1:0]  forward_speed_i;
  logic signed [FS_W-1:0]  turn_rate_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [DUTY_W-1:0]       left_duty_o;
  logic                    left_forward_o;
  logic [RPM_W-1:0]        left_rpm_o;
  logic [DUTY_W-1:0]       right_duty_o;
  logic                    right_forward_o;
  logic [RPM_W-1:0]        right_rpm_o;

  wheel_pwm_board board = new();
  logic steady = 1'b0;
  int unsigned cycles = 0;
  int unsigned settings = 1;

  diff_drive_wheel_pwm dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("tb_diff_drive_wheel_pwm failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_command(forward_speed_i, turn_rate_i);
      if (out_valid_o && out_ready_i) begin
        got.left_duty     = left_duty_o;
        got.left_forward  = left_forward_o;
        got.left_rpm      = left_rpm_o;
        got.right_duty    = right_duty_o;
        got.right_forward = right_forward_o;
        got.right_rpm     = right_rpm_o;
        board.check_result(got);
      end
    end
  end

  always @(negedge clk_i) out_ready_i <= steady || ($urandom_range(0, 99) >= 18);

  // hold the request until accepted, return at the following falling edge
  task automatic send_command(input logic signed [15:0] fs, input logic signed [15:0] tr);
    forward_speed_i <= fs;
    turn_rate_i     <= tr;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // drop valid for a random run of cycles, each with the same chance as an output stall
  task automatic maybe_idle();
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    board.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_setting(input logic [15:0] mx, input logic [15:0] circ,
                              input logic [15:0] track, input logic [15:0] gear,
                              input logic [15:0] ls, input logic [15:0] rs,
                              input logic [15:0] tg);
    write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_MAX_RPM, mx);
    write_reg(REG_WHEEL_CIRC, circ);
    write_reg(REG_WHEEL_TRACK, track);
    write_reg(REG_GEAR_RATIO, gear);
    write_reg(REG_LEFT_SCALE, ls);
    write_reg(REG_RIGHT_SCALE, rs);
    write_reg(REG_TURN_GAIN, tg);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  function automatic logic signed [15:0] pick_velocity();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return -16'sd1;
        3: return 16'sd1;
        default: return 16'sd0;
      endcase
    end
    if (sel < 6) return 16'($signed($urandom_range(0, 4096)) - 2048);
    return 16'($urandom);
  endfunction

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      send_command(pick_velocity(), pick_velocity());
      maybe_idle();
    end
  endtask

  logic signed [15:0] corner_fs[14] = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0,
    16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd1, -16'sd1, 16'sd0, 16'sd4096,
    -16'sd4096};
  logic signed [15:0] corner_tr[14] = '{16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000,
    16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, -16'sd1, 16'sd0,
    16'sd4096};

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_MAX_RPM;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    forward_speed_i = '0;
    turn_rate_i     = '0;
    out_ready_i     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners at the reset register values
    for (int k = 0; k < 14; k++) begin
      send_command(corner_fs[k], corner_tr[k]);
      maybe_idle();
    end
    run_random(80);

    // all registers at their top, then at one, with left scale and turn gain at zero
    wait_drained();
    load_setting(16'h3fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    run_random(40);
    wait_drained();
    load_setting(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'd0);
    run_random(40);

    // zero circumference acts as one LSB
    wait_drained();
    load_setting(16'h3fff, 16'd0, 16'd3277, 16'd256, 16'd16384, 16'd16384, 16'd4096);
    run_random(30);

    // upper bits of max rpm drop, leaving zero
    wait_drained();
    load_setting(16'h4000, 16'd13998, 16'd3277, 16'd256, 16'd16384, 16'd16384, 16'd4096);
    run_random(30);

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      if (ph[0])
        load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
      else
        load_setting(16'($urandom_range(1, 16383)) | 16'($urandom_range(0, 3) << 14),
                     16'($urandom_range(2000, 65535)), 16'($urandom),
                     16'($urandom_range(64, 1024)), 16'($urandom_range(0, 32768)),
                     16'($urandom_range(0, 32768)), 16'($urandom_range(0, 16384)));
      steady = (ph == 1);
      run_random(80);
      steady = 1'b0;
    end

    wait_drained();
    repeat (PIPE_LAT + 16) @(posedge clk_i);
    $display("%0d commands under %0d register settings, %0d wheel results compared",
             board.commands, settings, board.checked);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb_diff_drive_wheel_pwm passed");
    else
      $display("tb_diff_drive_wheel_pwm failed");
    $finish;
  end

endmodule
